/* design/u16u8_pkg.sv */
// Shared types and the UTF-8 byte encoder for the UTF-16 to UTF-8 transcoder.
// Used by the front end, the job queue and the back end. Depends on nothing.
`default_nettype none

package u16u8_pkg;

  // Code point width: supplementary planes reach 0x10FFFF.
  localparam int CP_W      = 21;
  localparam int MAX_BYTES = 6;
  localparam int CNT_W     = 3;

  // Encoding of one code point: up to four bytes, first byte at index 0.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [3:0][7:0]  bytes;
  } enc_t;

  // Work handed from front to back: all bytes one input unit produces.
  typedef struct packed {
    logic [CNT_W-1:0]           count;
    logic [MAX_BYTES-1:0][7:0]  bytes;
  } job_t;

  // Surrogate classes of a 16-bit code unit.
  localparam logic [5:0] LEAD_TAG  = 6'b110110;
  localparam logic [5:0] TRAIL_TAG = 6'b110111;

  // Plain UTF-8 encoding; code point zero yields no bytes.
  function automatic enc_t encode_cp(input logic [CP_W-1:0] cp);
    enc_t e;
    e = '0;
    if (cp == '0) begin
      e.count = 3'd0;
    end else if (cp < 21'h80) begin
      e.count    = 3'd1;
      e.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      e.count    = 3'd2;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.count    = 3'd3;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.count    = 3'd4;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

/* design/u16u8_stream_if.sv */
// Valid/ready channel interfaces of the transcoder: the code unit input
// channel and the byte output channel. No dependencies.
`default_nettype none

interface u16u8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface u16u8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

/* design/utf16_to_utf8_transcoder.sv */
// UTF-16 to UTF-8 transcoder top level: front end, job queue, back end.
// Depends on u16u8_pkg, the stream interfaces and the three submodules.
//
// The block accepts one UTF-16 code unit per cycle as long as the job
// queue (QUEUE_DEPTH entries) has room, and sends UTF-8 bytes at one byte
// per cycle while the output is ready. The bytes a unit produces number
// none for a zero unit or a held lead surrogate, one to three for
// a BMP character, four for a surrogate pair, and up to six when a flushed
// lead precedes a new character. The byte serializer in the back end sets
// the sustained rate; the first byte of a unit passes through the queue,
// the job register and the output register. run_last marks the final
// byte of each input unit that produces bytes.
`default_nettype none

module utf16_to_utf8_transcoder
  import u16u8_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst,
  u16u8_unit_if.sink   units,
  u16u8_byte_if.source bytes
);

  logic push;
  job_t push_job;
  logic q_full;
  logic q_pop;
  job_t q_job;
  logic q_empty;

  u16u8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .units    (units),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_job),
    .empty    (q_empty)
  );

  u16u8_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .bytes   (bytes)
  );

endmodule

`default_nettype wire

/* design/u16u8_front.sv */
// Front end: accepts code units, pairs surrogates, and builds the byte job
// for each unit. Depends on u16u8_pkg and u16u8_unit_if.
`default_nettype none

module u16u8_front
  import u16u8_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  u16u8_unit_if.sink    units,
  input  wire logic     q_full,
  output logic          push,
  output job_t          push_job
);

  logic       lead_pending;
  logic [9:0] held_lead_bits;

  logic            accept;
  logic            is_lead;
  logic            is_trail;
  logic            pair;
  logic            flush;
  logic            hold;
  logic [CP_W-1:0] cp;
  enc_t            unit_enc;
  enc_t            lead_enc;
  logic [CNT_W-1:0] unit_cnt;

  assign units.ready = !q_full;
  assign accept      = units.valid && units.ready;

  // Classify the unit against what is held.
  assign is_lead  = units.code_unit[15:10] == LEAD_TAG;
  assign is_trail = units.code_unit[15:10] == TRAIL_TAG;
  assign pair     = lead_pending && is_trail;
  assign flush    = lead_pending && !is_trail;
  assign hold     = !pair && is_lead && !units.last_unit;

  // Code point of this unit: a combined pair or the unit itself.
  always_comb begin
    if (pair) begin
      cp = CP_W'(21'h10000 + {1'b0, held_lead_bits, units.code_unit[9:0]});
    end else begin
      cp = CP_W'(units.code_unit);
    end
  end

  assign unit_enc = encode_cp(cp);
  assign lead_enc = encode_cp(CP_W'({LEAD_TAG, held_lead_bits}));
  assign unit_cnt = hold ? 3'd0 : unit_enc.count;

  // Assemble the job: a flushed lead goes first, then the unit's own bytes.
  always_comb begin
    push_job = '0;
    if (flush) begin
      push_job.bytes[0] = lead_enc.bytes[0];
      push_job.bytes[1] = lead_enc.bytes[1];
      push_job.bytes[2] = lead_enc.bytes[2];
      push_job.bytes[3] = unit_enc.bytes[0];
      push_job.bytes[4] = unit_enc.bytes[1];
      push_job.bytes[5] = unit_enc.bytes[2];
      push_job.count    = CNT_W'(3'd3 + unit_cnt);
    end else begin
      push_job.bytes[0] = unit_enc.bytes[0];
      push_job.bytes[1] = unit_enc.bytes[1];
      push_job.bytes[2] = unit_enc.bytes[2];
      push_job.bytes[3] = unit_enc.bytes[3];
      push_job.count    = unit_cnt;
    end
  end

  // Units that produce no bytes never enter the queue.
  assign push = accept && (push_job.count != '0);

  // Surrogate hold state.
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending <= 1'b0;
    end else if (accept) begin
      lead_pending <= hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead_bits <= '0;
    end else if (accept && hold) begin
      held_lead_bits <= units.code_unit[9:0];
    end
  end

endmodule

`default_nettype wire

/* design/u16u8_queue.sv */
// Short FIFO of byte jobs between front and back end.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_queue
  import u16u8_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_job,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

  job_t              entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full    = fill == FULL_FILL;
  assign empty   = fill == '0;
  assign pop_job = entries[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        fill <= FILL_W'(fill + 1'b1);
      end else if (pop && !push) begin
        fill <= FILL_W'(fill - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

/* design/u16u8_back.sv */
// Back end: takes queued jobs and sends their bytes one per cycle, when
// the output is ready, via an output register. Depends on u16u8_pkg, u16u8_byte_if.
`default_nettype none

module u16u8_back
  import u16u8_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  input  job_t       q_job,
  output logic       q_pop,
  u16u8_byte_if.source bytes
);

  job_t             job;
  logic             busy;
  logic [CNT_W-1:0] idx;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             run_last;

  logic load_en;
  logic at_last;
  logic free_next;

  assign bytes.valid    = out_valid;
  assign bytes.out_byte = out_byte;
  assign bytes.run_last = run_last;

  // The output register takes a byte whenever it is empty or being drained.
  assign load_en   = !out_valid || bytes.ready;
  assign at_last   = busy && (idx == CNT_W'(job.count - 1'b1));
  assign free_next = !busy || (load_en && at_last);
  assign q_pop     = free_next && !q_empty;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_en) begin
      out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && busy) begin
      out_byte <= job.bytes[idx];
      run_last <= at_last;
    end
  end

  // Current job and byte index.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (load_en && at_last) begin
      busy <= 1'b0;
    end else if (load_en && busy) begin
      idx <= CNT_W'(idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
  end

endmodule

`default_nettype wire
